FILE: hdl/assert_macros.svh
// assertion macros shared by the fetch block tracker modules
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define FBT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fbt assertion failed");

// condition must never be true outside reset
`define FBT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("fbt forbidden condition seen");

`else

`define FBT_ASSERT(lbl, clk, rstn, prop)
`define FBT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: hdl/fbt_pkg.sv
// shared types and constants of the fetch block tracker
// no dependencies
`timescale 1ns / 1ps

package fbt_pkg;

  localparam int unsigned PC_W       = 64;  // port width of addresses
  localparam int unsigned INSN_W     = 32;
  localparam int unsigned CNT_W      = 7;   // block count and limit
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SHIFT_W    = 4;

  localparam logic [CNT_W-1:0] LIMIT_MAX = 7'd127;
  localparam int unsigned INSN_BYTES = 4;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [CNT_W-1:0]   FETCH_WIDTH_RST = 7'd16;
  localparam logic [SHIFT_W-1:0] ALIGN_BITS_RST  = 4'd3;
  localparam logic [SHIFT_W-1:0] ROUND_BITS_RST  = 4'd6;
  localparam logic [SHIFT_W-1:0] BOUND_BITS_RST  = 4'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FETCH_WIDTH = 2'd0,
    CFG_ALIGN_BITS  = 2'd1,
    CFG_ROUND_BITS  = 2'd2,
    CFG_BOUND_BITS  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]   fetch_width;
    logic [SHIFT_W-1:0] align_bits;
    logic [SHIFT_W-1:0] round_bits;
    logic [SHIFT_W-1:0] bound_bits;
  } cfg_t;

endpackage

FILE: hdl/fbt_queue.sv
// small register queue that decouples the limit pipeline from the block tracker
// depends on fbt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbt_queue import fbt_pkg::*; #(
  parameter int unsigned WIDTH = 167
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [WIDTH-1:0]  data_o,
  output logic [QCNT_W-1:0] count_o
);

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // front reserves space before it takes an item, so a full queue never sees a push
  `FBT_NEVER(a_queue_overflow, clk_i, rst_ni,
             push_i && !pop_i && (count_q == QCNT_W'(QUEUE_DEPTH)))
  `FBT_NEVER(a_queue_underflow, clk_i, rst_ni, pop_i && (count_q == '0))

endmodule

FILE: hdl/fbt_front.sv
// front end: accepts items and computes each one's block limit in a short pipeline
// depends on fbt_pkg
`timescale 1ns / 1ps

module fbt_front import fbt_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PC_W-1:0]      pc_i,
  input  logic [INSN_W-1:0]    insn_i,
  input  logic [QCNT_W-1:0]    q_count_i,
  output logic                 q_push_o,
  output logic [2*ADDR_WIDTH+INSN_W+CNT_W-1:0] q_data_o
);

  localparam int unsigned AW = ADDR_WIDTH;

  logic          accept;
  logic [AW-1:0] pc_in;
  logic [AW-1:0] align_mask, bound_mask;
  logic [AW-1:0] end_round, end_width, end_near, end_cut;
  logic [AW-1:0] span_bytes;
  logic [AW-3:0] span;
  logic [CNT_W-1:0] limit;
  logic [QCNT_W+1:0] reserved;

  // stage 1: round and width boundaries
  logic          v1_q;
  logic [AW-1:0] pc1_q, pc4_1_q, end_round1_q, end_width1_q;
  logic [INSN_W-1:0] insn1_q;
  // stage 2: block end after the bound cut
  logic          v2_q;
  logic [AW-1:0] pc2_q, pc4_2_q, end2_q;
  logic [INSN_W-1:0] insn2_q;

  // space is reserved for every item still in the pipeline
  assign reserved   = (QCNT_W+2)'(q_count_i) + (QCNT_W+2)'(v1_q) + (QCNT_W+2)'(v2_q);
  assign in_stall_o = (reserved >= (QCNT_W+2)'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  assign pc_in      = pc_i[AW-1:0];
  assign align_mask = {AW{1'b1}} << cfg_i.align_bits;
  assign end_round  = (pc_in & align_mask) + (AW'(1) << cfg_i.round_bits);
  assign end_width  = pc_in + (AW'(cfg_i.fetch_width) << 2);

  assign bound_mask = {AW{1'b1}} << cfg_i.bound_bits;
  assign end_near   = (end_round1_q < end_width1_q) ? end_round1_q : end_width1_q;
  always_comb begin
    end_cut = end_near;
    if ((cfg_i.bound_bits != '0) && (((pc1_q ^ end_near) & bound_mask) != '0)) begin
      end_cut = end_near & bound_mask;
    end
  end

  assign span_bytes = end2_q - pc2_q;
  assign span       = span_bytes[AW-1:2];
  assign limit      = (span[AW-3:CNT_W] != '0) ? LIMIT_MAX : span[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pc1_q        <= pc_in;
      pc4_1_q      <= pc_in + AW'(INSN_BYTES);
      insn1_q      <= insn_i;
      end_round1_q <= end_round;
      end_width1_q <= end_width;
    end
    if (v1_q) begin
      pc2_q   <= pc1_q;
      pc4_2_q <= pc4_1_q;
      insn2_q <= insn1_q;
      end2_q  <= end_cut;
    end
  end

  assign q_push_o = v2_q;
  assign q_data_o = {pc2_q, pc4_2_q, insn2_q, limit};

endmodule

FILE: hdl/fbt_back.sv
// back end: tracks the open block, decides closes and holds the result register
// depends on fbt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbt_back import fbt_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  logic [2*ADDR_WIDTH+INSN_W+CNT_W-1:0] q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PC_W-1:0]      block_start_o,
  output logic [PC_W-1:0]      block_end_o,
  output logic [PC_W-1:0]      target_pc_o,
  output logic [INSN_W-1:0]    end_insn_o
);

  localparam int unsigned AW = ADDR_WIDTH;

  logic [AW-1:0]     item_pc, item_pc4;
  logic [INSN_W-1:0] item_insn;
  logic [CNT_W-1:0]  item_limit;
  logic              close, open;

  logic              started_q;
  logic [AW-1:0]     open_start_q, last_pc_q, next_pc_q;
  logic [INSN_W-1:0] last_word_q;
  logic [CNT_W-1:0]  count_q, limit_q;

  logic              out_valid_q;
  logic [AW-1:0]     out_start_q, out_end_q, out_target_q;
  logic [INSN_W-1:0] out_insn_q;

  assign {item_pc, item_pc4, item_insn, item_limit} = q_data_i;

  assign close   = started_q && ((count_q == limit_q) || (item_pc != next_pc_q));
  assign open    = !started_q || close;
  // hold the head item only while its result has nowhere to go
  assign q_pop_o = q_valid_i && !(close && out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      count_q     <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (q_pop_o) begin
        started_q <= 1'b1;
        if (open) begin
          count_q <= CNT_W'(1);
          limit_q <= item_limit;
        end else if (count_q < LIMIT_MAX) begin
          count_q <= count_q + 1'b1;
        end
        if (close) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (open) begin
        open_start_q <= item_pc;
      end
      last_pc_q   <= item_pc;
      next_pc_q   <= item_pc4;
      last_word_q <= item_insn;
      if (close) begin
        out_start_q  <= open_start_q;
        out_end_q    <= last_pc_q;
        out_target_q <= item_pc;
        out_insn_q   <= last_word_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign block_start_o = PC_W'(out_start_q);
  assign block_end_o   = PC_W'(out_end_q);
  assign target_pc_o   = PC_W'(out_target_q);
  assign end_insn_o    = out_insn_q;

  `FBT_ASSERT(a_started_sticky, clk_i, rst_ni, started_q |=> started_q)
  `FBT_ASSERT(a_count_nonzero, clk_i, rst_ni, started_q |-> (count_q != '0))
  `FBT_ASSERT(a_no_result_before_start, clk_i, rst_ni, !started_q |-> !out_valid_q)

endmodule

FILE: hdl/fetch_block_tracker.sv
// fetch block tracker top level: configuration registers, front, queue and back
// depends on fbt_pkg, fbt_front, fbt_queue and fbt_back
`timescale 1ns / 1ps

// Groups a stream of committed instructions (pc, instruction word) into fetch
// blocks and reports each block when it closes: start pc, pc of the last
// instruction, pc of the instruction that closed it, and the last instruction
// word. A block closes when its instruction count reaches the limit computed
// when it opened, or when the next pc is not the previous pc plus 4. The very
// first item only opens a block, and a block that is still open is never
// flushed. Items are taken one per cycle while in_stall_o is low; a result
// is presented once the item that closes the block has moved from the first
// front stage through the second front stage and the queue head into the
// result register. The front runs the 64-bit boundary adds, the
// compare and the span subtract one per stage and pushes into a four-entry
// queue; it stalls the input only when the queue plus its two pipeline stages
// would overflow. The back holds the open block and a single result register,
// so a stalled output stops the back only when the head item closes another
// block. Addresses are kept at ADDR_WIDTH bits and zero-extended on output.
// Configuration registers (write enable, index, data) take effect at once
// and are to be written only while the block is idle.

module fetch_block_tracker import fbt_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // committed instruction items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PC_W-1:0]       pc_i,
  input  logic [INSN_W-1:0]     insn_i,
  // closed block items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PC_W-1:0]       block_start_o,
  output logic [PC_W-1:0]       block_end_o,
  output logic [PC_W-1:0]       target_pc_o,
  output logic [INSN_W-1:0]     end_insn_o
);

  // queue entry: pc, pc plus 4, instruction word, block limit
  localparam int unsigned ITEM_W = 2 * ADDR_WIDTH + INSN_W + CNT_W;

  cfg_t cfg_q;

  logic              q_push, q_pop, q_valid;
  logic [ITEM_W-1:0] q_push_data, q_data;
  logic [QCNT_W-1:0] q_count;

  // configuration registers, one per index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fetch_width <= FETCH_WIDTH_RST;
      cfg_q.align_bits  <= ALIGN_BITS_RST;
      cfg_q.round_bits  <= ROUND_BITS_RST;
      cfg_q.bound_bits  <= BOUND_BITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FETCH_WIDTH: cfg_q.fetch_width <= cfg_data_i;
        CFG_ALIGN_BITS:  cfg_q.align_bits  <= cfg_data_i[SHIFT_W-1:0];
        CFG_ROUND_BITS:  cfg_q.round_bits  <= cfg_data_i[SHIFT_W-1:0];
        CFG_BOUND_BITS:  cfg_q.bound_bits  <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accepts items and works out each item's block limit
  fbt_front #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pc_i       (pc_i),
    .insn_i     (insn_i),
    .q_count_i  (q_count),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  // queue: lets the front keep going while the output is stalled
  fbt_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .count_o     (q_count)
  );

  // back: open block state, close decision and result register
  fbt_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .block_start_o (block_start_o),
    .block_end_o   (block_end_o),
    .target_pc_o   (target_pc_o),
    .end_insn_o    (end_insn_o)
  );

endmodule

FILE: verif/fetch_block_tracker_tb.sv
// self-checking testbench of the fetch block tracker: directed table, then random commit streams
// depends on fbt_pkg and fetch_block_tracker
`timescale 1ns / 1ps

module fetch_block_tracker_tb;
  import fbt_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 12;      // pipeline is four deep, leave slack
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned STREAM_ITEMS = 62;      // random items per setting, last run overshoots
  localparam int unsigned SETTINGS_PER_PHASE = 5;
  localparam int unsigned LONG_HOLD    = 150;     // receiver hold-off in cycles
  localparam int unsigned NUM_ROWS     = 25;

  typedef struct packed {
    logic [PC_W-1:0]   first_pc;
    logic [PC_W-1:0]   last_pc;
    logic [PC_W-1:0]   target_pc;
    logic [INSN_W-1:0] last_insn;
  } block_rec_t;

  typedef enum logic {ROW_INSN, ROW_REG} row_kind_e;

  // one line of the directed table: an item, or a register write
  typedef struct packed {
    row_kind_e             kind;
    cfg_reg_e              sel;
    logic [CFG_DATA_W-1:0] value;
    logic [PC_W-1:0]       pc;
    logic [INSN_W-1:0]     insn;
    logic                  typed;   // block below is typed in, not predicted
    block_rec_t            rec;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PC_W-1:0]       pc_i;
  logic [INSN_W-1:0]     insn_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PC_W-1:0]       block_start_o;
  logic [PC_W-1:0]       block_end_o;
  logic [PC_W-1:0]       target_pc_o;
  logic [INSN_W-1:0]     end_insn_o;

  // predictor copy of the registers
  logic [CNT_W-1:0]   cfg_fetch_width = FETCH_WIDTH_RST;
  logic [SHIFT_W-1:0] cfg_align       = ALIGN_BITS_RST;
  logic [SHIFT_W-1:0] cfg_round       = ROUND_BITS_RST;
  logic [SHIFT_W-1:0] cfg_bound       = BOUND_BITS_RST;

  // predictor copy of the open block
  logic               trk_started   = 1'b0;
  logic [PC_W-1:0]    trk_first     = '0;
  logic [PC_W-1:0]    trk_last_pc   = '0;
  logic [INSN_W-1:0]  trk_last_word = '0;
  logic [CNT_W-1:0]   trk_count     = '0;
  logic [CNT_W-1:0]   trk_limit     = '0;

  block_rec_t pending_blocks[$];
  row_t       directed_rows[NUM_ROWS];

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned fail_count;
  int unsigned insn_count;
  int unsigned blocks_checked;
  int unsigned settings_used;
  int unsigned in_held_cycles;
  int unsigned cycle_count;

  fetch_block_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pc_i          (pc_i),
    .insn_i        (insn_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .block_start_o (block_start_o),
    .block_end_o   (block_end_o),
    .target_pc_o   (target_pc_o),
    .end_insn_o    (end_insn_o)
  );

  always #5 clk_i = ~clk_i;

  // instruction limit of a block opening at pc: nearer of the round and width
  // ends, optionally cut back to a bound boundary, saturating at the max
  function automatic logic [CNT_W-1:0] insn_limit(input logic [PC_W-1:0] pc);
    logic [PC_W-1:0] aligned;
    logic [PC_W-1:0] round_end;
    logic [PC_W-1:0] width_end;
    logic [PC_W-1:0] stop;
    logic [PC_W-1:0] span;
    aligned   = (pc >> cfg_align) << cfg_align;
    round_end = aligned + (64'd1 << cfg_round);
    width_end = pc + {55'd0, cfg_fetch_width, 2'b00};
    stop      = (round_end < width_end) ? round_end : width_end;
    if (cfg_bound != '0 && ((pc ^ stop) >> cfg_bound) != '0) begin
      stop = (stop >> cfg_bound) << cfg_bound;
    end
    span = (stop - pc) >> 2;  // wraps when the end lies below pc
    return (span > {57'd0, LIMIT_MAX}) ? LIMIT_MAX : span[CNT_W-1:0];
  endfunction

  // advance the open block by one committed instruction; true when it closes one
  function automatic logic group_insn(input logic [PC_W-1:0] pc,
                                      input logic [INSN_W-1:0] insn,
                                      output block_rec_t rec);
    logic closes;
    logic opens;
    rec    = '0;
    closes = 1'b0;
    opens  = 1'b1;
    if (!trk_started) begin
      trk_started = 1'b1;  // very first item only opens a block
    end else if (trk_count == trk_limit || pc != trk_last_pc + 64'd4) begin
      closes = 1'b1;
      rec    = '{trk_first, trk_last_pc, pc, trk_last_word};
    end else begin
      opens = 1'b0;
      if (trk_count < LIMIT_MAX) trk_count++;
      trk_last_pc   = pc;
      trk_last_word = insn;
    end
    if (opens) begin
      trk_first     = pc;
      trk_limit     = insn_limit(pc);
      trk_last_pc   = pc;
      trk_last_word = insn;
      trk_count     = 7'd1;
    end
    return closes;
  endfunction

  function automatic row_t insn_row(input logic [PC_W-1:0] pc, input logic [INSN_W-1:0] insn);
    row_t r;
    r      = '0;
    r.kind = ROW_INSN;
    r.pc   = pc;
    r.insn = insn;
    return r;
  endfunction

  // item whose closed block is known by inspection
  function automatic row_t closing_row(input logic [PC_W-1:0] pc, input logic [INSN_W-1:0] insn,
                                       input logic [PC_W-1:0] first, input logic [PC_W-1:0] last,
                                       input logic [INSN_W-1:0] word);
    row_t r;
    r       = insn_row(pc, insn);
    r.typed = 1'b1;
    r.rec   = '{first, last, pc, word};
    return r;
  endfunction

  function automatic row_t reg_row(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] value);
    row_t r;
    r       = '0;
    r.kind  = ROW_REG;
    r.sel   = sel;
    r.value = value;
    return r;
  endfunction

  // random run start: near the top so runs wrap, low memory, word aligned, anything
  function automatic logic [PC_W-1:0] run_origin();
    logic [PC_W-1:0] pc;
    pc = {$urandom, $urandom};
    case ($urandom_range(3))
      0: pc = {56'hFF_FFFF_FFFF_FFFF, pc[7:0]};
      1: pc = {48'd0, pc[15:0]};
      2: pc[1:0] = 2'b00;
      default: ;
    endcase
    return pc;
  endfunction

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch %0d: %s", fail_count, what);
  endtask

  // entered and left at a falling edge; valid stays up when the next item follows
  task automatic send_insn(input logic [PC_W-1:0] pc, input logic [INSN_W-1:0] insn,
                           input logic typed, input block_rec_t typed_rec);
    block_rec_t rec;
    logic       closes;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pc_i       = pc;
    insn_i     = insn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    closes = group_insn(pc, insn, rec);
    if (typed) pending_blocks.push_back(typed_rec);
    else if (closes) pending_blocks.push_back(rec);
    insn_count++;
    @(negedge clk_i);
  endtask

  // drop valid, wait for every block, then let items with no block leave the pipe
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = sel;
    cfg_data_i = value;
    case (sel)
      CFG_FETCH_WIDTH: cfg_fetch_width = value;
      CFG_ALIGN_BITS:  cfg_align = value[SHIFT_W-1:0];
      CFG_ROUND_BITS:  cfg_round = value[SHIFT_W-1:0];
      CFG_BOUND_BITS:  cfg_bound = value[SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // reset values, all-ones extremes, all-zero extremes, then random settings
  task automatic apply_setting(input int unsigned k);
    logic [CNT_W-1:0]   fw;
    logic [SHIFT_W-1:0] al;
    logic [SHIFT_W-1:0] rb;
    logic [SHIFT_W-1:0] bb;
    case (k)
      0: {fw, al, rb, bb} = {FETCH_WIDTH_RST, ALIGN_BITS_RST, ROUND_BITS_RST, BOUND_BITS_RST};
      1: {fw, al, rb, bb} = {7'd127, 4'd15, 4'd15, 4'd15};
      2: {fw, al, rb, bb} = {7'd0, 4'd0, 4'd0, 4'd0};
      default: begin
        fw = CNT_W'($urandom_range(1, 64));
        al = SHIFT_W'($urandom_range(0, 12));
        rb = SHIFT_W'($urandom_range(2, 12));
        bb = $urandom_range(1) ? SHIFT_W'($urandom_range(1, 12)) : 4'd0;
      end
    endcase
    write_reg(CFG_FETCH_WIDTH, fw);
    write_reg(CFG_ALIGN_BITS, {3'd0, al});
    write_reg(CFG_ROUND_BITS, {3'd0, rb});
    write_reg(CFG_BOUND_BITS, {3'd0, bb});
    settings_used++;
  endtask

  // mostly sequential runs with random words, a few with a skipped slot,
  // some far longer than any limit, and scattered single pcs as noise
  task automatic send_stream(input int unsigned n);
    int unsigned     sent;
    int unsigned     run_len;
    logic [PC_W-1:0] pc;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 85) begin
        pc      = run_origin();
        run_len = ($urandom_range(15) == 0) ? $urandom_range(128, 140) : $urandom_range(1, 24);
        repeat (run_len) begin
          send_insn(pc, $urandom, 1'b0, '0);
          pc += ($urandom_range(29) == 0) ? 64'd8 : 64'd4;
        end
        sent += run_len;
      end else begin
        send_insn({$urandom, $urandom}, $urandom, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < out_idle_pct);
    end
  end

  // compare each block taken from the output with the oldest expectation
  always @(posedge clk_i) begin : check_blocks
    block_rec_t want;
    if (rst_ni && in_valid_i && in_stall_o) in_held_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_blocks.size() == 0) begin
        flag_mismatch($sformatf("unexpected block start=%h end=%h target=%h insn=%h",
                                block_start_o, block_end_o, target_pc_o, end_insn_o));
      end else begin
        want = pending_blocks.pop_front();
        blocks_checked++;
        if (block_start_o !== want.first_pc || block_end_o !== want.last_pc ||
            target_pc_o !== want.target_pc || end_insn_o !== want.last_insn) begin
          flag_mismatch($sformatf({"block start exp %h got %h, end exp %h got %h, ",
                                   "target exp %h got %h, insn exp %h got %h"},
                                  want.first_pc, block_start_o, want.last_pc, block_end_o,
                                  want.target_pc, target_pc_o, want.last_insn, end_insn_o));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d blocks still expected",
               cycle_count, pending_blocks.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_FETCH_WIDTH;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    pc_i           = '0;
    insn_i         = '0;
    in_idle_pct    = 14;
    out_idle_pct   = 47;
    hold_req       = 0;
    hold_left      = 0;
    fail_count     = 0;
    insn_count     = 0;
    blocks_checked = 0;
    settings_used  = 0;
    in_held_cycles = 0;
    cycle_count    = 0;

    directed_rows = '{
      insn_row(64'h1000, 32'h0000_0000),                 // first item only opens
      insn_row(64'h1004, 32'hFFFF_FFFF),
      closing_row(64'h2000, 32'h0000_0013, 64'h1000, 64'h1004, 32'hFFFF_FFFF),
      closing_row(64'hFFFF_FFFF_FFFF_FFFC, 32'hAAAA_AAAA, 64'h2000, 64'h2000, 32'h0000_0013),
      insn_row(64'h0, 32'h5555_5555),                    // pc + 4 wraps to zero
      closing_row(64'h8000_0000_0000_0001, 32'h8000_0000,
                  64'hFFFF_FFFF_FFFF_FFFC, 64'h0, 32'h5555_5555),
      reg_row(CFG_FETCH_WIDTH, 7'd2),
      closing_row(64'h100, 32'h1, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
                  32'h8000_0000),
      insn_row(64'h104, 32'h2),
      closing_row(64'h108, 32'h3, 64'h100, 64'h104, 32'h2),  // two-item limit reached
      reg_row(CFG_FETCH_WIDTH, 7'd0),                    // zero limit until the width is set again
      insn_row(64'h10C, 32'h4),
      insn_row(64'h110, 32'h5),
      insn_row(64'h114, 32'h6),
      insn_row(64'h118, 32'h7),
      insn_row(64'h200, 32'h8),
      reg_row(CFG_ALIGN_BITS, 7'd15),
      reg_row(CFG_ROUND_BITS, 7'd2),
      reg_row(CFG_FETCH_WIDTH, 7'd127),
      insn_row(64'h9000, 32'h9),                         // round end below pc, limit saturates
      insn_row(64'h9004, 32'hA),
      reg_row(CFG_BOUND_BITS, 7'd4),
      reg_row(CFG_ALIGN_BITS, 7'd0),
      insn_row(64'h101C, 32'hB),                         // end cut at a bound boundary
      insn_row(64'h1020, 32'hC)
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(directed_rows[i].sel, directed_rows[i].value);
      end else begin
        send_insn(directed_rows[i].pc, directed_rows[i].insn,
                  directed_rows[i].typed, directed_rows[i].rec);
      end
    end

    // random streams: sender-light idling, receiver-light idling, then none
    for (int unsigned phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 14 : (phase == 1) ? 47 : 0;
      out_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 14 : 0;
      for (int unsigned k = 0; k < SETTINGS_PER_PHASE; k++) begin
        settle();
        apply_setting(k);
        if (phase == 2 && k == 0) begin
          // receiver holds off while scattered pcs keep closing blocks
          hold_req = LONG_HOLD;
          repeat (40) send_insn({$urandom, $urandom}, $urandom, 1'b0, '0);
        end
        send_stream(STREAM_ITEMS);
      end
    end

    settle();
    $display("covered %0d insn items and %0d closed blocks over %0d register settings",
             insn_count, blocks_checked, settings_used);
    $display("input held off for %0d cycles, including one %0d-cycle output hold-off",
             in_held_cycles, LONG_HOLD);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
